### rtl/exlx_pkg.sv
// Shared types and constants for the expression lexer.
`default_nettype none

package exlx_pkg;

    // Token codes carried on the result channel.
    typedef enum logic [3:0] {
        TOK_ID     = 4'd0,
        TOK_NUM    = 4'd1,
        TOK_MINUS  = 4'd2,
        TOK_DIV    = 4'd3,
        TOK_PLUS   = 4'd4,
        TOK_MUL    = 4'd5,
        TOK_COMMA  = 4'd6,
        TOK_RPAREN = 4'd7,
        TOK_LPAREN = 4'd8,
        TOK_END    = 4'd9
    } tok_type_t;

    // Input item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Character codes that end a literal, and the bounds of the digit range.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Parenthesis depth counter.
    localparam int unsigned DEPTH_W = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Token record queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    // Slots of one token record, in emission order.
    localparam int unsigned SLOT_NUM  = 0;
    localparam int unsigned SLOT_MUL  = 1;
    localparam int unsigned SLOT_ID   = 2;
    localparam int unsigned SLOT_TAIL = 3;

    // All tokens caused by one input transaction.
    typedef struct packed {
        logic        has_num;
        logic        has_mul;
        logic        has_id;
        logic        has_tail;
        tok_type_t   tail_type;
        logic        status;
        logic [63:0] num;
        logic [15:0] id_start;
        logic [15:0] id_len;
    } lex_rec_t;

endpackage

`default_nettype wire

### rtl/exlx_front.sv
// Front end: accepts characters, keeps the lexer state and builds token records.
`default_nettype none

module exlx_front #(
    parameter int unsigned NUM_WIDTH = 64,
    parameter int unsigned POS_WIDTH = 16
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    input  wire              in_ready,
    input  wire              in_kind,
    input  wire        [7:0] in_symbol,
    output logic             rec_push,
    output exlx_pkg::lex_rec_t rec
);
    import exlx_pkg::*;

    logic [POS_WIDTH-1:0] position_reg,  position_next;
    logic [DEPTH_W-1:0]   depth_reg,     depth_next;
    logic                 in_lit_reg,    in_lit_next;
    logic                 prefix_reg,    prefix_next;
    logic [NUM_WIDTH-1:0] accum_reg,     accum_next;
    logic [POS_WIDTH-1:0] lit_start_reg, lit_start_next;
    logic [POS_WIDTH-1:0] lit_count_reg, lit_count_next;
    logic [POS_WIDTH-1:0] dig_count_reg, dig_count_next;
    logic                 error_reg,     error_next;

    logic                 accept;
    logic                 is_end;
    logic                 is_delim;
    logic                 is_digit;
    logic                 flush;
    tok_type_t            op_type;
    logic [POS_WIDTH-1:0] id_start_w;
    logic [POS_WIDTH-1:0] id_len_w;
    logic [31:0]          id_start_ext;
    logic [31:0]          id_len_ext;
    logic                 prefix_eff;
    logic [NUM_WIDTH-1:0] accum_eff;
    logic [POS_WIDTH-1:0] lit_count_eff;
    logic [POS_WIDTH-1:0] dig_count_eff;
    logic [NUM_WIDTH-1:0] digit_val;

    assign accept   = in_valid && in_ready;
    assign is_end   = (in_kind == KIND_END);
    assign is_digit = (in_symbol >= CH_ZERO) && (in_symbol <= CH_NINE);
    // The low nibble of an ASCII digit is its value.
    assign digit_val = NUM_WIDTH'(in_symbol[3:0]);

    // Classify the delimiter characters.
    always_comb begin
        is_delim = 1'b1;
        op_type  = TOK_PLUS;
        case (in_symbol)
            CH_SPACE:  op_type = TOK_PLUS;
            CH_LPAREN: op_type = TOK_LPAREN;
            CH_RPAREN: op_type = TOK_RPAREN;
            CH_PLUS:   op_type = TOK_PLUS;
            CH_MINUS:  op_type = TOK_MINUS;
            CH_DIV:    op_type = TOK_DIV;
            CH_MUL:    op_type = TOK_MUL;
            CH_COMMA:  op_type = TOK_COMMA;
            default:   is_delim = 1'b0;
        endcase
    end

    // Identifier offset and length follow the leading digits.
    assign id_start_w   = lit_start_reg + dig_count_reg;
    assign id_len_w     = lit_count_reg - dig_count_reg;
    assign id_start_ext = 32'(id_start_w);
    assign id_len_ext   = 32'(id_len_w);

    // Build the token record for this transaction.
    assign flush = is_end || (!error_reg && is_delim);
    always_comb begin
        rec.has_num   = flush && in_lit_reg && (dig_count_reg != '0);
        rec.has_id    = flush && in_lit_reg && !prefix_reg;
        rec.has_mul   = rec.has_num && rec.has_id;
        rec.has_tail  = is_end || (!error_reg && is_delim && (in_symbol != CH_SPACE));
        rec.tail_type = is_end ? TOK_END : op_type;
        rec.status    = is_end && (error_reg || (depth_reg != '0));
        rec.num       = 64'(accum_reg);
        rec.id_start  = id_start_ext[15:0];
        rec.id_len    = id_len_ext[15:0];
    end
    assign rec_push = accept && (rec.has_num || rec.has_id || rec.has_tail);

    // A literal character starts a fresh literal when none is open.
    assign prefix_eff    = in_lit_reg ? prefix_reg    : 1'b1;
    assign accum_eff     = in_lit_reg ? accum_reg     : '0;
    assign lit_count_eff = in_lit_reg ? lit_count_reg : '0;
    assign dig_count_eff = in_lit_reg ? dig_count_reg : '0;

    // Lexer state update.
    always_comb begin
        position_next  = position_reg;
        depth_next     = depth_reg;
        in_lit_next    = in_lit_reg;
        prefix_next    = prefix_reg;
        accum_next     = accum_reg;
        lit_start_next = lit_start_reg;
        lit_count_next = lit_count_reg;
        dig_count_next = dig_count_reg;
        error_next     = error_reg;
        if (accept) begin
            if (is_end) begin
                position_next  = '0;
                depth_next     = '0;
                in_lit_next    = 1'b0;
                prefix_next    = 1'b0;
                accum_next     = '0;
                lit_start_next = '0;
                lit_count_next = '0;
                dig_count_next = '0;
                error_next     = 1'b0;
            end else begin
                position_next = position_reg + 1'b1;
                if (!error_reg) begin
                    if (is_delim) begin
                        in_lit_next    = 1'b0;
                        prefix_next    = 1'b0;
                        accum_next     = '0;
                        lit_count_next = '0;
                        dig_count_next = '0;
                        if (in_symbol == CH_LPAREN) begin
                            if (depth_reg != DEPTH_MAX) begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end else if (in_symbol == CH_RPAREN) begin
                            if (depth_reg == '0) begin
                                error_next = 1'b1;
                            end else begin
                                depth_next = depth_reg - 1'b1;
                            end
                        end
                    end else begin
                        in_lit_next = 1'b1;
                        if (!in_lit_reg) begin
                            lit_start_next = position_reg;
                        end
                        if (prefix_eff && is_digit) begin
                            prefix_next    = 1'b1;
                            accum_next     = (accum_eff << 3) + (accum_eff << 1) + digit_val;
                            dig_count_next = (dig_count_eff == '1) ? dig_count_eff
                                                                   : dig_count_eff + 1'b1;
                        end else begin
                            prefix_next    = 1'b0;
                            accum_next     = accum_eff;
                            dig_count_next = dig_count_eff;
                        end
                        lit_count_next = lit_count_eff + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            depth_reg     <= '0;
            in_lit_reg    <= 1'b0;
            prefix_reg    <= 1'b0;
            accum_reg     <= '0;
            lit_start_reg <= '0;
            lit_count_reg <= '0;
            dig_count_reg <= '0;
            error_reg     <= 1'b0;
        end else begin
            position_reg  <= position_next;
            depth_reg     <= depth_next;
            in_lit_reg    <= in_lit_next;
            prefix_reg    <= prefix_next;
            accum_reg     <= accum_next;
            lit_start_reg <= lit_start_next;
            lit_count_reg <= lit_count_next;
            dig_count_reg <= dig_count_next;
            error_reg     <= error_next;
        end
    end

endmodule

`default_nettype wire

### rtl/exlx_queue.sv
// Small register queue of token records between the front and the back.
`default_nettype none

module exlx_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  wire exlx_pkg::lex_rec_t push_rec,
    input  wire                     pop,
    output exlx_pkg::lex_rec_t      head_rec,
    output logic                    full,
    output logic                    empty
);
    import exlx_pkg::*;

    lex_rec_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg,  count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = slots_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

### rtl/exlx_back.sv
// Back end: expands each token record into result transactions, one per cycle while m_ready allows.
`default_nettype none

module exlx_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire exlx_pkg::lex_rec_t head_rec,
    input  wire                     q_empty,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic              [3:0] m_token_type,
    output logic             [63:0] m_number_value,
    output logic             [15:0] m_ident_start,
    output logic             [15:0] m_ident_length,
    output logic                    m_status,
    output logic                    m_last_of_run
);
    import exlx_pkg::*;

    logic [3:0]  done_reg, done_next;
    logic        valid_reg, valid_next;
    tok_type_t   type_reg, type_next;
    logic [63:0] value_reg, value_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] len_reg, len_next;
    logic        status_reg, status_next;
    logic        last_reg, last_next;

    logic [3:0]  present;
    logic [3:0]  remaining;
    logic [3:0]  sel;
    logic        is_last;
    logic        load;

    // Tokens of the head record not yet sent, lowest slot first.
    assign present   = {head_rec.has_tail, head_rec.has_id, head_rec.has_mul, head_rec.has_num};
    assign remaining = present & ~done_reg;
    assign sel       = remaining & (~remaining + 4'd1);
    assign is_last   = ((remaining & ~sel) == 4'd0);
    assign load      = !q_empty && (!valid_reg || m_ready);
    assign q_pop     = load && is_last;

    // Output register load.
    always_comb begin
        done_next   = done_reg;
        valid_next  = valid_reg;
        type_next   = type_reg;
        value_next  = value_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next  = 1'b1;
            done_next   = is_last ? 4'd0 : (done_reg | sel);
            last_next   = is_last;
            value_next  = '0;
            start_next  = '0;
            len_next    = '0;
            status_next = 1'b0;
            if (sel[SLOT_NUM]) begin
                type_next  = TOK_NUM;
                value_next = head_rec.num;
            end else if (sel[SLOT_MUL]) begin
                type_next = TOK_MUL;
            end else if (sel[SLOT_ID]) begin
                type_next  = TOK_ID;
                start_next = head_rec.id_start;
                len_next   = head_rec.id_len;
            end else begin
                type_next   = head_rec.tail_type;
                status_next = head_rec.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg   <= type_next;
        value_reg  <= value_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_token_type   = type_reg;
    assign m_number_value = value_reg;
    assign m_ident_start  = start_reg;
    assign m_ident_length = len_reg;
    assign m_status       = status_reg;
    assign m_last_of_run  = last_reg;

endmodule

`default_nettype wire

### rtl/expression_lexer_core.sv
// Top level of the expression lexer: front end, token record queue and back end.
`default_nettype none

// The lexer takes one character transaction per cycle on the s_ channel while
// s_ready is high and emits one token per cycle on the m_ channel while
// m_ready is high. The front end updates the lexer state for each accepted
// character and writes one record into a four-entry queue for every character
// or end item that produces tokens; the back end sends the tokens of a record
// one per cycle as m_ready allows, at most four per item. Characters that
// produce no token (literal characters, ignored characters after an error)
// never enter the queue. s_ready drops only while the queue is full, which
// happens when delimiters that flush literals arrive faster than their tokens
// drain. There is no clearing pass after reset.
module expression_lexer_core #(
    parameter int unsigned NUM_WIDTH = 64,
    parameter int unsigned POS_WIDTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_kind,
    input  wire   [7:0] s_symbol,
    output logic        m_valid,
    input  wire         m_ready,
    output logic  [3:0] m_token_type,
    output logic [63:0] m_number_value,
    output logic [15:0] m_ident_start,
    output logic [15:0] m_ident_length,
    output logic        m_status,
    output logic        m_last_of_run
);
    import exlx_pkg::*;

    lex_rec_t push_rec;
    lex_rec_t head_rec;
    logic     rec_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    assign s_ready = !q_full;

    exlx_front #(
        .NUM_WIDTH (NUM_WIDTH),
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_kind   (s_kind),
        .in_symbol (s_symbol),
        .rec_push  (rec_push),
        .rec       (push_rec)
    );

    exlx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (rec_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    exlx_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_rec       (head_rec),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_type   (m_token_type),
        .m_number_value (m_number_value),
        .m_ident_start  (m_ident_start),
        .m_ident_length (m_ident_length),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run)
    );

`ifndef SYNTHESIS
    // The end token always closes the run of its transaction.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_token_type == TOK_END)) |-> m_last_of_run)
        else $error("end token without last_of_run");

    // Only number tokens carry a value.
    a_value_only_on_num: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_token_type != TOK_NUM)) |-> (m_number_value == 64'd0))
        else $error("nonzero value on a non-number token");

    // Status is reported on the end token only.
    a_status_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_token_type == TOK_END))
        else $error("status set on a non-end token");

    // Input is held off only when the queue is full.
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> !q_empty)
        else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire
